// ===== hw/rtl/rfpl_pkg.sv =====
// shared types, codes and constants of the refcounted free page list
`default_nettype none

package rfpl_pkg;

   // fixed field widths of the transactions
   localparam int OP_W       = 2;
   localparam int PAGE_NUM_W = 10;
   localparam int REF_CNT_W  = 8;
   localparam int STATUS_W   = 2;

   // default sizing
   localparam int PAGE_COUNT_DEF = 1024;
   localparam int COUNT_BITS_DEF = 8;

   // width of the shift amount used while folding page_index into range
   localparam int RED_K_W = $clog2(PAGE_NUM_W);

   // operation codes
   localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OP_W-1:0] OP_RESERVE = 2'd1;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
   localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;
   localparam logic [STATUS_W-1:0] ST_SAT   = 2'd3;

   // number of compare-subtract steps that bring a page_index below page_count
   function automatic int reduce_steps(int page_count);
      int n;
      n = 0;
      for (int k = 0; k < PAGE_NUM_W; k++) begin
         if ((page_count << k) < (1 << PAGE_NUM_W)) begin
            n = k + 1;
         end
      end
      return n;
   endfunction

   // controller to datapath
   typedef struct packed {
      logic               clear_wr;
      logic               capture;
      logic               reduce;
      logic [RED_K_W-1:0] red_k;
      logic               rd_head;
      logic               rd_page;
      logic               exec;
      logic               link;
   } rfpl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic link_needed;
   } rfpl_sts_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rfpl_if.sv =====
// request and response channel interfaces of the refcounted free page list
`default_nettype none

interface rfpl_req_if;
   logic                             valid;
   logic                             ready;
   logic [rfpl_pkg::OP_W-1:0]        op;
   logic [rfpl_pkg::PAGE_NUM_W-1:0]  page_index;

   modport source (output valid, output op, output page_index, input ready);
   modport sink   (input valid, input op, input page_index, output ready);
endinterface

interface rfpl_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [rfpl_pkg::PAGE_NUM_W-1:0]  page_number;
   logic [rfpl_pkg::REF_CNT_W-1:0]   ref_count;
   logic [rfpl_pkg::STATUS_W-1:0]    status;
   logic                             list_empty;

   modport source (output valid, output page_number, output ref_count, output status,
                   output list_empty, input ready);
   modport sink   (input valid, input page_number, input ref_count, input status,
                   input list_empty, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rfpl_datapath.sv =====
// link and count memories, head registers and response payload registers
`default_nettype none

module rfpl_datapath #(
   parameter int PAGE_COUNT = rfpl_pkg::PAGE_COUNT_DEF,
   parameter int COUNT_BITS = rfpl_pkg::COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rfpl_pkg::rfpl_cmd_type              cmd,
   output rfpl_pkg::rfpl_sts_type              sts,
   input  logic [rfpl_pkg::OP_W-1:0]           req_op,
   input  logic [rfpl_pkg::PAGE_NUM_W-1:0]     req_page_index,
   output logic [rfpl_pkg::PAGE_NUM_W-1:0]     rsp_page_number,
   output logic [rfpl_pkg::REF_CNT_W-1:0]      rsp_ref_count,
   output logic [rfpl_pkg::STATUS_W-1:0]       rsp_status,
   output logic                                rsp_list_empty
);

   localparam int IW = $clog2(PAGE_COUNT);
   localparam int CW = COUNT_BITS;
   localparam int PW = rfpl_pkg::PAGE_NUM_W;
   localparam logic [IW-1:0] LAST_PAGE = IW'(PAGE_COUNT - 1);
   localparam logic [CW-1:0] CNT_MAX   = '1;
   localparam logic [CW-1:0] CNT_ONE   = CW'(1);

   logic [IW-1:0] next_link_mem [PAGE_COUNT];
   logic [IW-1:0] prev_link_mem [PAGE_COUNT];
   logic [CW-1:0] use_count_mem [PAGE_COUNT];

   logic [rfpl_pkg::OP_W-1:0] op_ff, op_in;
   logic [PW-1:0]             idx_ff, idx_in;
   logic [IW-1:0]             page_ff, page_in;
   logic [IW-1:0]             head_ff, head_in;
   logic                      head_valid_ff, head_valid_in;
   logic [IW-1:0]             clr_ff, clr_in;
   logic [IW-1:0]             nxt_rd_ff, prv_rd_ff;
   logic [CW-1:0]             cnt_rd_ff;

   logic [PW-1:0]                    rsp_page_number_ff;
   logic [rfpl_pkg::REF_CNT_W-1:0]   rsp_ref_count_ff;
   logic [rfpl_pkg::STATUS_W-1:0]    rsp_status_ff;
   logic                             rsp_list_empty_ff;

   // index folding
   logic [PW:0] red_sub, red_diff;

   // read side
   logic [IW-1:0] page_sel, next_raddr;
   logic          rd_en;

   // operation results
   logic [CW-1:0]                 res_cnt, cnt_wdata_op;
   logic [rfpl_pkg::STATUS_W-1:0] res_status;
   logic                          res_blank, cnt_upd, unlink, ins_first, ins_alone;
   logic [IW-1:0]                 head_new;
   logic                          hv_new;

   // write ports
   logic          next_we, prev_we, cnt_we;
   logic [IW-1:0] next_waddr, next_wdata, prev_waddr, prev_wdata, cnt_waddr;
   logic [CW-1:0] cnt_wdata;

   // capture and fold page_index below PAGE_COUNT one shifted subtract at a time
   always_comb begin
      red_sub  = (PW + 1)'(PAGE_COUNT) << cmd.red_k;
      red_diff = {1'b0, idx_ff} - red_sub;
      op_in    = op_ff;
      idx_in   = idx_ff;
      if (cmd.capture) begin
         op_in  = req_op;
         idx_in = req_page_index;
      end else if (cmd.reduce && !red_diff[PW]) begin
         idx_in = red_diff[PW-1:0];
      end
   end

   // allocate takes its page from the next link of the head
   assign page_sel   = (op_ff == rfpl_pkg::OP_ALLOC) ? nxt_rd_ff : IW'(idx_ff);
   assign page_in    = cmd.rd_page ? page_sel : page_ff;
   assign next_raddr = (cmd.rd_head || op_ff == rfpl_pkg::OP_RELEASE) ? head_ff : page_sel;
   assign rd_en      = cmd.rd_head || cmd.rd_page;

   always_comb begin
      res_cnt      = cnt_rd_ff;
      res_status   = rfpl_pkg::ST_OK;
      res_blank    = 1'b0;
      cnt_upd      = 1'b0;
      cnt_wdata_op = cnt_rd_ff;
      unlink       = 1'b0;
      ins_first    = 1'b0;
      ins_alone    = 1'b0;
      head_new     = head_ff;
      hv_new       = head_valid_ff;
      case (op_ff)
         rfpl_pkg::OP_ALLOC, rfpl_pkg::OP_RESERVE: begin
            if (op_ff == rfpl_pkg::OP_ALLOC && !head_valid_ff) begin
               res_status = rfpl_pkg::ST_EMPTY;
               res_blank  = 1'b1;
            end else if (cnt_rd_ff == CNT_MAX) begin
               res_status = rfpl_pkg::ST_SAT;
            end else begin
               cnt_upd      = 1'b1;
               cnt_wdata_op = cnt_rd_ff + CNT_ONE;
               res_cnt      = cnt_wdata_op;
               // zero count means the page sits on the list
               if (cnt_rd_ff == '0) begin
                  unlink = 1'b1;
                  if (head_valid_ff && head_ff == page_ff) begin
                     if (nxt_rd_ff != page_ff) begin
                        head_new = nxt_rd_ff;
                     end else begin
                        hv_new = 1'b0;
                     end
                  end
               end
            end
         end
         rfpl_pkg::OP_RELEASE: begin
            if (cnt_rd_ff == '0) begin
               res_status = rfpl_pkg::ST_UNDER;
            end else begin
               cnt_upd      = 1'b1;
               cnt_wdata_op = cnt_rd_ff - CNT_ONE;
               res_cnt      = cnt_wdata_op;
               if (cnt_rd_ff == CNT_ONE) begin
                  if (head_valid_ff) begin
                     ins_first = 1'b1;
                  end else begin
                     ins_alone = 1'b1;
                     head_new  = page_ff;
                     hv_new    = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // write port selection
   always_comb begin
      next_we    = 1'b0;
      next_waddr = page_ff;
      next_wdata = page_ff;
      prev_we    = 1'b0;
      prev_waddr = page_ff;
      prev_wdata = page_ff;
      cnt_we     = 1'b0;
      cnt_waddr  = page_ff;
      cnt_wdata  = cnt_wdata_op;
      if (cmd.clear_wr) begin
         next_we    = 1'b1;
         next_waddr = clr_ff;
         next_wdata = (clr_ff == LAST_PAGE) ? '0 : clr_ff + IW'(1);
         prev_we    = 1'b1;
         prev_waddr = clr_ff;
         prev_wdata = (clr_ff == '0) ? LAST_PAGE : clr_ff - IW'(1);
         cnt_we     = 1'b1;
         cnt_waddr  = clr_ff;
         cnt_wdata  = '0;
      end else if (cmd.link) begin
         // second half of an insert after the head
         next_we    = 1'b1;
         next_waddr = head_ff;
         next_wdata = page_ff;
         prev_we    = 1'b1;
         prev_waddr = page_ff;
         prev_wdata = head_ff;
      end else if (cmd.exec) begin
         cnt_we = cnt_upd;
         if (unlink) begin
            next_we    = 1'b1;
            next_waddr = prv_rd_ff;
            next_wdata = nxt_rd_ff;
            prev_we    = 1'b1;
            prev_waddr = nxt_rd_ff;
            prev_wdata = prv_rd_ff;
         end else if (ins_first) begin
            next_we    = 1'b1;
            next_waddr = page_ff;
            next_wdata = nxt_rd_ff;
            prev_we    = 1'b1;
            prev_waddr = nxt_rd_ff;
            prev_wdata = page_ff;
         end else if (ins_alone) begin
            next_we = 1'b1;
            prev_we = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_link_mem[next_waddr] <= next_wdata;
      end
      if (rd_en) begin
         nxt_rd_ff <= next_link_mem[next_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_link_mem[prev_waddr] <= prev_wdata;
      end
      if (cmd.rd_page) begin
         prv_rd_ff <= prev_link_mem[page_sel];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         use_count_mem[cnt_waddr] <= cnt_wdata;
      end
      if (cmd.rd_page) begin
         cnt_rd_ff <= use_count_mem[page_sel];
      end
   end

   assign clr_in        = cmd.clear_wr ? clr_ff + IW'(1) : clr_ff;
   assign head_in       = cmd.exec ? head_new : head_ff;
   assign head_valid_in = cmd.exec ? hv_new : head_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= '0;
         head_ff       <= '0;
         head_valid_ff <= 1'b1;
      end else begin
         clr_ff        <= clr_in;
         head_ff       <= head_in;
         head_valid_ff <= head_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      idx_ff  <= idx_in;
      page_ff <= page_in;
      if (cmd.exec) begin
         rsp_page_number_ff <= res_blank ? '0 : PW'(page_ff);
         rsp_ref_count_ff   <= res_blank ? '0 : rfpl_pkg::REF_CNT_W'(res_cnt);
         rsp_status_ff      <= res_status;
         rsp_list_empty_ff  <= !hv_new;
      end
   end

   assign sts.clear_last  = (clr_ff == LAST_PAGE);
   assign sts.link_needed = ins_first;

   assign rsp_page_number = rsp_page_number_ff;
   assign rsp_ref_count   = rsp_ref_count_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_list_empty  = rsp_list_empty_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rfpl_ctrl.sv =====
// sequencing state machine and response valid flag
`default_nettype none

module rfpl_ctrl #(
   parameter int PAGE_COUNT = rfpl_pkg::PAGE_COUNT_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rfpl_pkg::rfpl_cmd_type  cmd,
   input  rfpl_pkg::rfpl_sts_type  sts
);

   localparam int RED_STEPS = rfpl_pkg::reduce_steps(PAGE_COUNT);
   localparam logic [rfpl_pkg::RED_K_W-1:0] RED_TOP =
      rfpl_pkg::RED_K_W'((RED_STEPS > 0) ? RED_STEPS - 1 : 0);

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_REDUCE = 7'b0000100,
      S_HEAD   = 7'b0001000,
      S_READ   = 7'b0010000,
      S_EXEC   = 7'b0100000,
      S_LINK   = 7'b1000000
   } state_type;

   state_type                    state_ff, state_in;
   logic [rfpl_pkg::RED_K_W-1:0] k_ff, k_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               k_in        = RED_TOP;
               state_in    = (RED_STEPS > 0) ? S_REDUCE : S_HEAD;
            end
         end
         S_REDUCE: begin
            cmd.reduce = 1'b1;
            cmd.red_k  = k_ff;
            if (k_ff == '0) begin
               state_in = S_HEAD;
            end else begin
               k_in = k_ff - rfpl_pkg::RED_K_W'(1);
            end
         end
         S_HEAD: begin
            cmd.rd_head = 1'b1;
            state_in    = S_READ;
         end
         S_READ: begin
            cmd.rd_page = 1'b1;
            state_in    = S_EXEC;
         end
         S_EXEC: begin
            if (out_free) begin
               cmd.exec = 1'b1;
               state_in = sts.link_needed ? S_LINK : S_IDLE;
            end
         end
         S_LINK: begin
            cmd.link = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // a new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   a_exec_presents: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_valid_ff)
      else $error("executed transaction not presented");

   a_link_after_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LINK) |-> $past(cmd.exec))
      else $error("link step without executed release");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (state_ff == S_CLEAR && !rsp_valid_ff))
      else $error("reset did not start clearing pass");

endmodule

`default_nettype wire

// ===== hw/rtl/refcounted_free_page_list_top.sv =====
// top level of the refcounted free page list
`default_nettype none

// physical page allocator: a circular doubly linked free list of PAGE_COUNT
// pages with a COUNT_BITS reference count per page; each request transaction
// allocates the page after the head, reserves a named page or releases one, and
// yields exactly one response transaction with the page, its new count, a status
// code and the list empty flag; after reset a clearing pass over every page
// rebuilds the links and zeroes the counts, during which no request is taken;
// a transaction runs through accept, head link read, page read, and execute and
// write back, plus a link step for a release that returns a page to a nonempty
// list, since the next-link and prev-link memories take one write each per cycle,
// and, when PAGE_COUNT is below 1024, folding steps of page_index between accept
// and the head link read (one step, plus one more for each time PAGE_COUNT can be
// doubled while staying below 1024); a new request is taken while the previous
// response still waits on rsp_bus, and its execute step then holds until that
// response is taken
module refcounted_free_page_list_top #(
   parameter int PAGE_COUNT = rfpl_pkg::PAGE_COUNT_DEF,
   parameter int COUNT_BITS = rfpl_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   rfpl_req_if.sink    req_bus,
   rfpl_rsp_if.source  rsp_bus
);

   // command and status between sequencer and datapath
   rfpl_pkg::rfpl_cmd_type cmd;
   rfpl_pkg::rfpl_sts_type sts;

   // sequencer owns both handshakes
   rfpl_ctrl #(
      .PAGE_COUNT (PAGE_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // memories, head pointer and response payload
   rfpl_datapath #(
      .PAGE_COUNT (PAGE_COUNT),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_op          (req_bus.op),
      .req_page_index  (req_bus.page_index),
      .rsp_page_number (rsp_bus.page_number),
      .rsp_ref_count   (rsp_bus.ref_count),
      .rsp_status      (rsp_bus.status),
      .rsp_list_empty  (rsp_bus.list_empty)
   );

endmodule

`default_nettype wire
